// ----- hdl/radar_measurement_jacobian_defines.svh -----
// Assertion macros shared by the radar measurement Jacobian RTL.
// Included by the modules that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RMJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RMJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/rmj_pkg.sv -----
// Shared widths, item types and the saturation helper for the radar Jacobian.
// No dependencies; used by the front end, the back end and the top level.
package rmj_pkg;

  localparam int W  = 32;          // word width of the data ports and result fields
  localparam int F  = 16;          // fraction bits
  localparam int PW = 2 * W;       // exact products, S and |D|
  localparam int SATW = W + 2 * F + 1;
  localparam int QDEPTH_DEF = 4;
  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] MIN_RADIUS_SQ_RST = CFG_W'(7);

  // Back pipeline: W root steps, then F+1 quotient steps, then multiply, then finish.
  localparam int NST = W + F + 3;

  typedef struct packed {
    logic          deg;
    logic          spx;
    logic          spy;
    logic          sd;
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [PW-1:0] s;
    logic [PW-1:0] dm;
  } fr_t;

  typedef struct packed {
    logic              deg;
    logic              spx;
    logic              spy;
    logic              sd;
    logic [PW-1:0]     s;
    logic [W+1:0]      sq_rem;
    logic [W-1:0]      root;
    logic [PW+F-1:0]   qrem;
    logic [W+F-1:0]    q;
    logic              qov;
    logic [PW-1:0]     pa_rem;
    logic [PW-1:0]     pb_rem;
    logic [W:0]        pa_q;
    logic [W:0]        pb_q;
    logic [W+F-1:0]    mx_rem;
    logic [W+F-1:0]    my_rem;
    logic [F:0]        mx;
    logic [F:0]        my;
    logic [SATW-1:0]   px_prod;
    logic [SATW-1:0]   py_prod;
    logic [W-1:0]      o_rx;
    logic [W-1:0]      o_ry;
    logic [W-1:0]      o_px;
    logic [W-1:0]      o_py;
    logic [W-1:0]      o_dx;
    logic [W-1:0]      o_dy;
    logic              o_deg;
  } bk_t;

  typedef struct packed {
    logic [W-1:0] rx;
    logic [W-1:0] ry;
    logic [W-1:0] px;
    logic [W-1:0] py;
    logic [W-1:0] dx;
    logic [W-1:0] dy;
    logic         deg;
  } res_t;

  // Clamp a magnitude to the signed word range and apply the sign.
  function automatic logic [W-1:0] sat_fn(input logic [SATW-1:0] mag, input logic neg);
    logic [SATW-1:0] cap;
    logic [SATW-1:0] v;
    logic [W-1:0]    vw;
    cap = neg ? (SATW'(1) << (W - 1)) : ((SATW'(1) << (W - 1)) - SATW'(1));
    v   = (mag > cap) ? cap : mag;
    vw  = v[W-1:0];
    return neg ? (~vw + W'(1)) : vw;
  endfunction

endpackage

// ----- hdl/rmj_front.sv -----
// Front end: takes items, forms magnitudes, squares and cross products, and classifies
// degenerate inputs. Depends on rmj_pkg.
module rmj_front import rmj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_full_o,
  input  logic signed [W-1:0] pos_x_i,
  input  logic signed [W-1:0] pos_y_i,
  input  logic signed [W-1:0] vel_x_i,
  input  logic signed [W-1:0] vel_y_i,
  input  logic [CFG_W-1:0]    thr_i,
  input  logic                q_full_i,
  output logic                ent_push_o,
  output fr_t                 ent_o
);

  logic          en;
  logic          v1_q, v2_q, v3_q;
  logic [W-1:0]  a1_q, b1_q, vx1_q, vy1_q;
  logic          spx1_q, spy1_q, svx1_q, svy1_q;
  logic [W-1:0]  a2_q, b2_q;
  logic          spx2_q, spy2_q, s1_2_q, s2_2_q;
  logic [PW-1:0] aa_q, bb_q, t1_q, t2_q;
  logic [W-1:0]  pxu, pyu, vxu, vyu;
  logic [PW-1:0] s_sum, thr;
  fr_t           fr_d, fr_q;

  // The whole front holds when its last item cannot enter the queue.
  assign en         = !(v3_q && q_full_i);
  assign in_full_o  = !en;
  assign ent_push_o = v3_q && !q_full_i;
  assign ent_o      = fr_q;

  assign pxu = pos_x_i;
  assign pyu = pos_y_i;
  assign vxu = vel_x_i;
  assign vyu = vel_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      spx1_q <= pxu[W-1];
      spy1_q <= pyu[W-1];
      svx1_q <= vxu[W-1];
      svy1_q <= vyu[W-1];
      a1_q   <= pxu[W-1] ? (~pxu + W'(1)) : pxu;
      b1_q   <= pyu[W-1] ? (~pyu + W'(1)) : pyu;
      vx1_q  <= vxu[W-1] ? (~vxu + W'(1)) : vxu;
      vy1_q  <= vyu[W-1] ? (~vyu + W'(1)) : vyu;

      a2_q   <= a1_q;
      b2_q   <= b1_q;
      spx2_q <= spx1_q;
      spy2_q <= spy1_q;
      s1_2_q <= svx1_q ^ spy1_q;
      s2_2_q <= svy1_q ^ spx1_q;
      aa_q   <= PW'(a1_q) * PW'(a1_q);
      bb_q   <= PW'(b1_q) * PW'(b1_q);
      t1_q   <= PW'(vx1_q) * PW'(b1_q);
      t2_q   <= PW'(vy1_q) * PW'(a1_q);

      fr_q   <= fr_d;
    end
  end

  assign s_sum = aa_q + bb_q;
  assign thr   = PW'(thr_i) << F;

  // D = Vx*Py - Vy*Px kept as sign and magnitude.
  always_comb begin
    fr_d     = '0;
    fr_d.a   = a2_q;
    fr_d.b   = b2_q;
    fr_d.spx = spx2_q;
    fr_d.spy = spy2_q;
    fr_d.s   = s_sum;
    fr_d.deg = (s_sum == '0) || (s_sum < thr);
    if (s1_2_q != s2_2_q) begin
      fr_d.dm = t1_q + t2_q;
      fr_d.sd = s1_2_q;
    end else if (t1_q >= t2_q) begin
      fr_d.dm = t1_q - t2_q;
      fr_d.sd = s1_2_q;
    end else begin
      fr_d.dm = t2_q - t1_q;
      fr_d.sd = !s1_2_q;
    end
  end

endmodule

// ----- hdl/rmj_queue.sv -----
// Short register queue between the front end and the back end.
// Depends on the assertion macros header.
`include "radar_measurement_jacobian_defines.svh"
module rmj_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `RMJ_ASSERT(a_no_overflow, push_i |-> (!full_o || pop_i), "item pushed into a full queue")
  `RMJ_ASSERT(a_no_underflow, pop_i |-> !empty_o, "item taken from an empty queue")
  `RMJ_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue fill count beyond depth")

endmodule

// ----- hdl/rmj_back.sv -----
// Back end: pipelined square root, restoring dividers and the final products and
// saturation, one step per stage. Depends on rmj_pkg.
module rmj_back import rmj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ent_vld_i,
  input  fr_t  ent_i,
  output logic ent_take_o,
  output logic res_vld_o,
  output res_t res_o,
  input  logic res_pop_i
);

  bk_t            ent;
  bk_t            stg_q [NST];
  logic [NST-1:0] vld_q;
  logic           adv;

  // The pipeline moves unless the finished item at its end is still waiting.
  assign adv        = !(vld_q[NST-1] && !res_pop_i);
  assign ent_take_o = ent_vld_i && adv;
  assign res_vld_o  = vld_q[NST-1];

  always_comb begin
    ent        = '0;
    ent.deg    = ent_i.deg;
    ent.spx    = ent_i.spx;
    ent.spy    = ent_i.spy;
    ent.sd     = ent_i.sd;
    ent.s      = ent_i.s;
    ent.qrem   = (PW + F)'(ent_i.dm) << F;
    // A quotient |D| * 2^F / S at or beyond 2^(W+F) saturates each rate entry whose range-row factor is nonzero.
    ent.qov    = (ent_i.dm >> W) >= ent_i.s;
    ent.pa_rem = PW'(ent_i.a) << W;
    ent.pb_rem = PW'(ent_i.b) << W;
    ent.mx_rem = (W + F)'(ent_i.a) << F;
    ent.my_rem = (W + F)'(ent_i.b) << F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], ent_vld_i};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stg
    localparam int SI = (k < W) ? 2 * (W - 1 - k) : 0;
    localparam int PI = (k <= W) ? (W - k) : 0;
    localparam int QI = (k < W + F) ? (W + F - 1 - k) : 0;
    localparam int MI = ((k >= W) && (k <= W + F)) ? (W + F - k) : 0;

    bk_t                 cur, nxt;
    logic [W+3:0]        sq_rem, sq_try;
    logic [PW+W:0]       p_div, pa_ext, pb_ext;
    logic [PW+W+F-1:0]   q_div, q_ext;
    logic [W+F:0]        m_div, mx_ext, my_ext;
    logic [SATW-1:0]     mg_dx, mg_dy;

    if (k == 0) begin : g_in
      assign cur = ent;
    end else begin : g_mid
      assign cur = stg_q[k-1];
    end

    always_comb begin
      nxt    = cur;
      sq_rem = {cur.sq_rem, cur.s[SI+1 -: 2]};
      sq_try = {2'b00, cur.root, 2'b01};
      p_div  = {{(W + 1){1'b0}}, cur.s} << PI;
      pa_ext = {{(W + 1){1'b0}}, cur.pa_rem};
      pb_ext = {{(W + 1){1'b0}}, cur.pb_rem};
      q_div  = {{(W + F){1'b0}}, cur.s} << QI;
      q_ext  = {{W{1'b0}}, cur.qrem};
      m_div  = {{(F + 1){1'b0}}, cur.root} << MI;
      mx_ext = {1'b0, cur.mx_rem};
      my_ext = {1'b0, cur.my_rem};
      mg_dx  = '0;
      mg_dy  = '0;

      // Digit-by-digit integer square root, two bits of S per stage.
      if (k < W) begin
        if (sq_rem >= sq_try) begin
          nxt.sq_rem = (W + 2)'(sq_rem - sq_try);
          nxt.root   = {cur.root[W-2:0], 1'b1};
        end else begin
          nxt.sq_rem = sq_rem[W+1:0];
          nxt.root   = {cur.root[W-2:0], 1'b0};
        end
      end

      // Bearing row: |P| * 2^(2F) / S, one quotient bit per stage.
      if (k <= W) begin
        if (pa_ext >= p_div) begin
          nxt.pa_rem   = PW'(pa_ext - p_div);
          nxt.pa_q[PI] = 1'b1;
        end
        if (pb_ext >= p_div) begin
          nxt.pb_rem   = PW'(pb_ext - p_div);
          nxt.pb_q[PI] = 1'b1;
        end
      end

      // |D| * 2^F / S, capped by the overflow flag.
      if (k < W + F) begin
        if (q_ext >= q_div) begin
          nxt.qrem  = (PW + F)'(q_ext - q_div);
          nxt.q[QI] = 1'b1;
        end
      end

      // Range row: |P| * 2^F / R once the root is complete.
      if ((k >= W) && (k <= W + F)) begin
        if (mx_ext >= m_div) begin
          nxt.mx_rem = (W + F)'(mx_ext - m_div);
          nxt.mx[MI] = 1'b1;
        end
        if (my_ext >= m_div) begin
          nxt.my_rem = (W + F)'(my_ext - m_div);
          nxt.my[MI] = 1'b1;
        end
      end

      if (k == W + F + 1) begin
        nxt.px_prod = SATW'(cur.q) * SATW'(cur.my);
        nxt.py_prod = SATW'(cur.q) * SATW'(cur.mx);
      end

      if (k == W + F + 2) begin
        if (cur.qov) begin
          mg_dx = (cur.my != '0) ? '1 : '0;
          mg_dy = (cur.mx != '0) ? '1 : '0;
        end else begin
          mg_dx = cur.px_prod >> F;
          mg_dy = cur.py_prod >> F;
        end
        if (cur.deg) begin
          nxt.o_rx  = '0;
          nxt.o_ry  = '0;
          nxt.o_px  = '0;
          nxt.o_py  = '0;
          nxt.o_dx  = '0;
          nxt.o_dy  = '0;
          nxt.o_deg = 1'b1;
        end else begin
          nxt.o_rx  = sat_fn(SATW'(cur.mx), cur.spx);
          nxt.o_ry  = sat_fn(SATW'(cur.my), cur.spy);
          nxt.o_px  = sat_fn(SATW'(cur.pb_q), !cur.spy);
          nxt.o_py  = sat_fn(SATW'(cur.pa_q), cur.spx);
          nxt.o_dx  = sat_fn(mg_dx, cur.spy != cur.sd);
          nxt.o_dy  = sat_fn(mg_dy, cur.spx == cur.sd);
          nxt.o_deg = 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign res_o.rx  = stg_q[NST-1].o_rx;
  assign res_o.ry  = stg_q[NST-1].o_ry;
  assign res_o.px  = stg_q[NST-1].o_px;
  assign res_o.py  = stg_q[NST-1].o_py;
  assign res_o.dx  = stg_q[NST-1].o_dx;
  assign res_o.dy  = stg_q[NST-1].o_dy;
  assign res_o.deg = stg_q[NST-1].o_deg;

endmodule

// ----- hdl/radar_measurement_jacobian.sv -----
// Top level of the radar polar measurement Jacobian: config register, front end,
// queue and back end. Depends on rmj_pkg, rmj_front, rmj_queue and rmj_back.
//
//   channel   handshake              payload
//   input     push / full            pos_x_i pos_y_i vel_x_i vel_y_i
//   result    empty / pop            drho_*, dphi_*, drate_*, degenerate_o
//   config    cfg_valid_i/ready_o    cfg_data_i (min_radius_sq)
//
// One item per cycle when nothing stalls; an item passes the front registers, the queue and
// W+F+3 back stages (51 for 32-bit words), set by the pipelined root and dividers.
// The front and back stall independently; the queue absorbs QDEPTH items between them.
// Reset is asynchronous and active low, clears all valid state and sets the threshold to 7.
`include "radar_measurement_jacobian_defines.svh"
module radar_measurement_jacobian import rmj_pkg::*; #(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic signed [W-1:0] pos_x_i,
  input  logic signed [W-1:0] pos_y_i,
  input  logic signed [W-1:0] vel_x_i,
  input  logic signed [W-1:0] vel_y_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [W-1:0] drho_dpx_o,
  output logic signed [W-1:0] drho_dpy_o,
  output logic signed [W-1:0] dphi_dpx_o,
  output logic signed [W-1:0] dphi_dpy_o,
  output logic signed [W-1:0] drate_dpx_o,
  output logic signed [W-1:0] drate_dpy_o,
  output logic                degenerate_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam logic signed [W-1:0] ONE = W'(1) << F;

  logic [CFG_W-1:0] min_rsq_q;
  logic             f_push, q_full, q_empty, q_pop;
  fr_t              f_ent, q_ent;
  logic [$bits(fr_t)-1:0] q_rdata;
  res_t             res;
  logic             res_vld;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rsq_q <= MIN_RADIUS_SQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_rsq_q <= cfg_data_i;
    end
  end

  rmj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (push),
    .in_full_o  (full),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .thr_i      (min_rsq_q),
    .q_full_i   (q_full),
    .ent_push_o (f_push),
    .ent_o      (f_ent)
  );

  rmj_queue #(
    .DEPTH (QDEPTH),
    .WIDTH ($bits(fr_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign q_ent = fr_t'(q_rdata);

  rmj_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ent_vld_i  (!q_empty),
    .ent_i      (q_ent),
    .ent_take_o (q_pop),
    .res_vld_o  (res_vld),
    .res_o      (res),
    .res_pop_i  (pop)
  );

  assign empty        = !res_vld;
  assign drho_dpx_o   = res.rx;
  assign drho_dpy_o   = res.ry;
  assign dphi_dpx_o   = res.px;
  assign dphi_dpy_o   = res.py;
  assign drate_dpx_o  = res.dx;
  assign drate_dpy_o  = res.dy;
  assign degenerate_o = res.deg;

  `RMJ_ASSERT(a_deg_zero, (!empty && degenerate_o) |-> (drho_dpx_o == '0 && drho_dpy_o == '0 && dphi_dpx_o == '0 && dphi_dpy_o == '0 && drate_dpx_o == '0 && drate_dpy_o == '0), "degenerate item with nonzero entries")
  `RMJ_ASSERT(a_rho_bound, (!empty && !degenerate_o) |-> (drho_dpx_o <= ONE && drho_dpx_o >= -ONE && drho_dpy_o <= ONE && drho_dpy_o >= -ONE), "range row entry beyond one")

endmodule
